[sv/bwm_pkg.sv]
// Shared types, constants and the byte-counter step for the burst-locked write merger.
// No dependencies.
`default_nettype none

package bwm_pkg;

  localparam int unsigned PAYLOAD_BITS_DEF = 48;
  localparam int unsigned BEAT_BYTES_DEF   = 32;
  localparam int unsigned QUEUE_DEPTH      = 2;
  localparam int unsigned SIZE_BITS        = 16;
  localparam int unsigned SRC_BITS         = 3;

  localparam logic [SRC_BITS-1:0] SRC_NONE     = 3'd0;
  localparam logic [SRC_BITS-1:0] SRC_INLINE   = 3'd1;
  localparam logic [SRC_BITS-1:0] SRC_LINE_UPD = 3'd2;
  localparam logic [SRC_BITS-1:0] SRC_SLAB_UPD = 3'd3;
  localparam logic [SRC_BITS-1:0] SRC_NEW_LINE = 3'd4;

  typedef struct packed {
    logic                 accepted;
    logic                 two;
    logic [SIZE_BITS-1:0] size1;
    logic [SIZE_BITS-1:0] size2;
  } hdr_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic [SIZE_BITS-1:0] left;
    logic                 freed;
  } beat_res_t;

  // One beat: load an idle counter, then drop by a beat or clear and free.
  function automatic beat_res_t beat_step(input logic [SIZE_BITS-1:0] left,
                                          input logic [SIZE_BITS-1:0] size,
                                          input logic [SIZE_BITS-1:0] bb);
    beat_res_t            r;
    logic [SIZE_BITS-1:0] ld;
    ld = (left == '0) ? size : left;
    if (ld > bb) begin
      r.left  = ld - bb;
      r.freed = 1'b0;
    end else begin
      r.left  = '0;
      r.freed = 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/bwm_front.sv]
// Front end: takes offers, checks the burst lock and updates lock and byte counter.
// Depends on bwm_pkg.
`default_nettype none

module bwm_front #(
  parameter int unsigned BEAT_BYTES   = bwm_pkg::BEAT_BYTES_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [bwm_pkg::SRC_BITS-1:0]   source_id_i,
  input  wire logic [bwm_pkg::SIZE_BITS-1:0]  first_size_i,
  input  wire logic                           has_second_i,
  input  wire logic [bwm_pkg::SIZE_BITS-1:0]  second_size_i,
  input  wire bwm_pkg::q_status_t             q_status_i,
  output logic                                push_o,
  output bwm_pkg::hdr_t                       hdr_o
);
  import bwm_pkg::*;

  localparam logic [SIZE_BITS-1:0] BB = SIZE_BITS'(BEAT_BYTES);

  logic [SRC_BITS-1:0]  owner_q, owner_d;
  logic [SIZE_BITS-1:0] left_q, left_d;
  logic                 src_ok, ok, two;
  beat_res_t            r1, r2;

  assign in_stall_o = q_status_i.full;
  assign push_o     = in_valid_i & ~q_status_i.full;

  assign src_ok = (source_id_i >= SRC_INLINE) && (source_id_i <= SRC_NEW_LINE);
  assign ok     = src_ok && ((owner_q == SRC_NONE) || (owner_q == source_id_i));
  assign two    = ok && has_second_i && (source_id_i <= SRC_SLAB_UPD);

  assign r1 = beat_step(left_q, first_size_i, BB);
  assign r2 = beat_step(r1.left, second_size_i, BB);

  always_comb begin
    owner_d = owner_q;
    left_d  = left_q;
    if (push_o && ok) begin
      owner_d = r1.freed ? SRC_NONE : source_id_i;
      left_d  = r1.left;
      if (two) begin
        left_d = r2.left;
        if (r2.freed) owner_d = SRC_NONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owner_q <= SRC_NONE;
      left_q  <= '0;
    end else begin
      owner_q <= owner_d;
      left_q  <= left_d;
    end
  end

  assign hdr_o.accepted = ok;
  assign hdr_o.two      = two;
  assign hdr_o.size1    = first_size_i;
  assign hdr_o.size2    = second_size_i;

  a_owner_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (owner_q <= SRC_NEW_LINE)) else $error("lock owner out of range");
  a_refuse_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && !ok) |=> ($stable(owner_q) && $stable(left_q)))
    else $error("refused offer changed lock state");

endmodule

`default_nettype wire

[sv/bwm_queue.sv]
// Short word queue between front and back.
// Depends on bwm_pkg.
`default_nettype none

module bwm_queue #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = bwm_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output bwm_pkg::q_status_t    status_o
);
  import bwm_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  assign status_o.full  = (cnt_q == FULL_CNT);
  assign status_o.empty = (cnt_q == '0);
  assign rdata_o        = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) wptr_d = (wptr_q == LAST_PTR) ? '0 : wptr_q + 1'b1;
    if (pop_i)  rptr_d = (rptr_q == LAST_PTR) ? '0 : rptr_q + 1'b1;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= wdata_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!status_o.full || pop_i)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty) else $error("queue underflow");

endmodule

`default_nettype wire

[sv/bwm_back.sv]
// Back end: plays queued offers out as one or two beats, or one refusal word.
// Depends on bwm_pkg.
`default_nettype none

module bwm_back #(
  parameter int unsigned PAYLOAD_BITS = bwm_pkg::PAYLOAD_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire bwm_pkg::q_status_t            q_status_i,
  input  wire bwm_pkg::hdr_t                 hdr_i,
  input  wire logic [PAYLOAD_BITS-1:0]       pay1_i,
  input  wire logic [PAYLOAD_BITS-1:0]       pay2_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               accepted_o,
  output logic [bwm_pkg::SIZE_BITS-1:0]      beat_size_o,
  output logic [PAYLOAD_BITS-1:0]            beat_payload_o,
  output logic                               last_o
);
  import bwm_pkg::*;

  logic phase_q, phase_d;
  logic take;

  assign out_valid_o = ~q_status_i.empty;
  assign take        = out_valid_o & ~out_stall_i;

  assign accepted_o     = hdr_i.accepted;
  assign last_o         = ~hdr_i.two | phase_q;
  assign beat_size_o    = !hdr_i.accepted ? '0 : (phase_q ? hdr_i.size2 : hdr_i.size1);
  assign beat_payload_o = !hdr_i.accepted ? '0 : (phase_q ? pay2_i : pay1_i);

  assign pop_o = take & last_o;

  always_comb begin
    phase_d = phase_q;
    if (take) phase_d = ~last_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) phase_q <= 1'b0;
    else         phase_q <= phase_d;
  end

  a_phase_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (out_valid_o && hdr_i.two && hdr_i.accepted))
    else $error("second beat without a two-beat offer at the head");

endmodule

`default_nettype wire

[sv/burst_locked_write_merger_top.sv]
// Burst-locked write merger, top level: front, queue and back.
// Depends on bwm_pkg, bwm_front, bwm_queue, bwm_back.
// The first word of an offer is driven from the queue head once the queue has registered it.
// Throughput: one output word per cycle while out_stall_i is low; a two-beat offer holds
//   the single output port for both its beats; the front takes an offer per cycle while the
//   two-entry queue has room.
// Reset clears the lock owner, the byte counter, the queue and the beat phase.
`default_nettype none

module burst_locked_write_merger_top #(
  parameter int unsigned PAYLOAD_BITS = bwm_pkg::PAYLOAD_BITS_DEF,
  parameter int unsigned BEAT_BYTES   = bwm_pkg::BEAT_BYTES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [bwm_pkg::SRC_BITS-1:0]  source_id_i,
  input  wire logic [bwm_pkg::SIZE_BITS-1:0] first_size_i,
  input  wire logic [PAYLOAD_BITS-1:0]       first_payload_i,
  input  wire logic                          has_second_i,
  input  wire logic [bwm_pkg::SIZE_BITS-1:0] second_size_i,
  input  wire logic [PAYLOAD_BITS-1:0]       second_payload_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               accepted_o,
  output logic [bwm_pkg::SIZE_BITS-1:0]      beat_size_o,
  output logic [PAYLOAD_BITS-1:0]            beat_payload_o,
  output logic                               last_o
);
  import bwm_pkg::*;

  localparam int unsigned QW = $bits(hdr_t) + 2 * PAYLOAD_BITS;

  q_status_t               q_status;
  logic                    push, pop;
  hdr_t                    hdr_in, hdr_out;
  logic [QW-1:0]           q_wdata, q_rdata;
  logic [PAYLOAD_BITS-1:0] pay1, pay2;

  bwm_front #(
    .BEAT_BYTES  (BEAT_BYTES)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .source_id_i     (source_id_i),
    .first_size_i    (first_size_i),
    .has_second_i    (has_second_i),
    .second_size_i   (second_size_i),
    .q_status_i      (q_status),
    .push_o          (push),
    .hdr_o           (hdr_in)
  );

  // payloads travel beside the header straight into the queue
  assign q_wdata = {hdr_in, first_payload_i, second_payload_i};

  bwm_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (q_wdata),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .status_o(q_status)
  );

  assign {hdr_out, pay1, pay2} = q_rdata;

  bwm_back #(
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_status_i    (q_status),
    .hdr_i         (hdr_out),
    .pay1_i        (pay1),
    .pay2_i        (pay2),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .accepted_o    (accepted_o),
    .beat_size_o   (beat_size_o),
    .beat_payload_o(beat_payload_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire
